@@ rtl/core/hash_table_perturbed_probe_lookup_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Hash table lookup unit assertion macros
// Concurrent assertion helpers clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_PERTURBED_PROBE_LOOKUP_UNIT_ASSERT_SVH
`define HASH_TABLE_PERTURBED_PROBE_LOOKUP_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTPL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/htpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Hash table lookup package
// Sizes, codes and control structures shared by the lookup unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htpl_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int PROBE_LIMIT  = 1024;
    localparam int PROBE_W      = $clog2(PROBE_LIMIT);
    localparam int LOG2_MAX     = 8;
    localparam int PERTURB_STEP_BITS = 5;
    localparam int HASH_W       = 64;
    localparam int KEY_W        = 64;
    localparam int MARK_W       = 2;
    localparam int ENTRY_W      = MARK_W + HASH_W + KEY_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOG2_SIZE = 1'b0,
        CFG_KEY_TYPE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KEY_INT32 = 2'd0,
        KEY_INT64 = 2'd1,
        KEY_FP32  = 2'd2,
        KEY_FP64  = 2'd3
    } t_key_type;

    typedef enum logic [1:0] {
        OUT_FOUND   = 2'd0,
        OUT_EMPTY   = 2'd1,
        OUT_DELETED = 2'd2,
        OUT_LIMIT   = 2'd3
    } t_outcome;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_PROBE = 1'b1
    } t_state;

    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/htpl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/htpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Hash table lookup controller
// Accepts words, sequences probes and hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htpl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_operation,
    input  htpl_pkg::t_status i_status,
    output logic             o_in_ready,
    output htpl_pkg::t_cmd   o_cmd
);

    htpl_pkg::t_state r_state;
    htpl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htpl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            htpl_pkg::ST_IDLE: begin
                if (i_in_valid && (i_operation == htpl_pkg::OP_LOOKUP)) begin
                    n_state = htpl_pkg::ST_PROBE;
                end
            end
            htpl_pkg::ST_PROBE: begin
                if (i_status.done && i_status.out_free) begin
                    n_state = htpl_pkg::ST_IDLE;
                end
            end
            default: n_state = htpl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            htpl_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.write  = i_in_valid && (i_operation == htpl_pkg::OP_WRITE);
                o_cmd.start  = i_in_valid && (i_operation == htpl_pkg::OP_LOOKUP);
            end
            htpl_pkg::ST_PROBE: begin
                o_cmd.step   = !i_status.done;
                o_cmd.finish = i_status.done && i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/htpl_datapath.sv @@
// ----------------------------------------------------------------------------
// Hash table lookup datapath
// Slot storage, probe sequence arithmetic, key comparison and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htpl_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [htpl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [htpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                      i_slot_index,
    input  logic                            i_slot_used,
    input  logic                            i_slot_deleted,
    input  logic signed [63:0]              i_hash,
    input  logic [63:0]                     i_key,
    input  htpl_pkg::t_cmd                  i_cmd,
    input  logic                            i_out_ready,
    output htpl_pkg::t_status               o_status,
    output logic                            o_out_valid,
    output logic [7:0]                      o_slot,
    output logic [1:0]                      o_outcome
);

    localparam int AW = htpl_pkg::ADDR_W;

    logic [3:0]                       r_log2_size;
    htpl_pkg::t_key_type              r_key_type;
    logic [htpl_pkg::TABLE_DEPTH-1:0] r_valid;
    logic                             r_vld;
    logic [htpl_pkg::HASH_W-1:0]      r_hash;
    logic [htpl_pkg::KEY_W-1:0]       r_key;
    logic [htpl_pkg::HASH_W-1:0]      r_perturb;
    logic [AW-1:0]                    r_i;
    logic [AW-1:0]                    r_slot;
    logic [htpl_pkg::PROBE_W-1:0]     r_n;
    logic                             r_have_free;
    logic [AW-1:0]                    r_free;
    logic                             r_out_valid;
    logic [AW-1:0]                    r_out_slot;
    htpl_pkg::t_outcome               r_out_outcome;

    logic [3:0]                       w_lg;
    logic [AW-1:0]                    w_mask;
    logic [AW-1:0]                    n_i;
    logic [AW-1:0]                    w_raddr;
    logic                             w_re;
    logic [htpl_pkg::ENTRY_W-1:0]     w_wdata;
    logic [htpl_pkg::ENTRY_W-1:0]     w_rdata;
    logic [htpl_pkg::MARK_W-1:0]      w_mark;
    logic [htpl_pkg::HASH_W-1:0]      w_st_hash;
    logic [htpl_pkg::KEY_W-1:0]       w_st_key;
    logic                             w_used;
    logic                             w_deleted;
    logic                             w_match;
    logic                             w_last;
    logic                             w_done;
    logic [AW-1:0]                    n_out_slot;
    htpl_pkg::t_outcome               n_out_outcome;

    function automatic logic keys_equal(input htpl_pkg::t_key_type kt,
                                        input logic [63:0] a,
                                        input logic [63:0] b);
        logic eq;
        eq = 1'b0;
        unique case (kt)
            htpl_pkg::KEY_INT32: eq = (a[31:0] == b[31:0]);
            htpl_pkg::KEY_INT64: eq = (a == b);
            htpl_pkg::KEY_FP32: begin
                if (((a[30:23] == 8'hFF) && (a[22:0] != '0)) ||
                    ((b[30:23] == 8'hFF) && (b[22:0] != '0))) begin
                    eq = 1'b0;
                end else if ((a[30:0] == '0) && (b[30:0] == '0)) begin
                    eq = 1'b1;
                end else begin
                    eq = (a[31:0] == b[31:0]);
                end
            end
            htpl_pkg::KEY_FP64: begin
                if (((a[62:52] == 11'h7FF) && (a[51:0] != '0)) ||
                    ((b[62:52] == 11'h7FF) && (b[51:0] != '0))) begin
                    eq = 1'b0;
                end else if ((a[62:0] == '0) && (b[62:0] == '0)) begin
                    eq = 1'b1;
                end else begin
                    eq = (a == b);
                end
            end
            default: eq = 1'b0;
        endcase
        return eq;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_size <= 4'd3;
            r_key_type  <= htpl_pkg::KEY_INT64;
        end else if (i_cfg_we) begin
            unique case (htpl_pkg::t_cfg_idx'(i_cfg_index))
                htpl_pkg::CFG_LOG2_SIZE: r_log2_size <= i_cfg_data[3:0];
                htpl_pkg::CFG_KEY_TYPE:  r_key_type  <= htpl_pkg::t_key_type'(i_cfg_data[1:0]);
                default: r_log2_size <= r_log2_size;
            endcase
        end
    end

    always_comb begin
        if (r_log2_size < 4'd1) begin
            w_lg = 4'd1;
        end else if (r_log2_size > 4'(htpl_pkg::LOG2_MAX)) begin
            w_lg = 4'(htpl_pkg::LOG2_MAX);
        end else begin
            w_lg = r_log2_size;
        end
        for (int b = 0; b < AW; b++) begin
            w_mask[b] = (b < int'(w_lg));
        end
    end

    assign n_i     = (r_i << 2) + r_i + r_perturb[AW-1:0] + AW'(1);
    assign w_raddr = i_cmd.start ? (AW'(i_hash) & w_mask) : (n_i & w_mask);
    assign w_re    = i_cmd.start || i_cmd.step;
    assign w_wdata = {i_slot_deleted, i_slot_used, i_hash, i_key};

    htpl_ram #(
        .WIDTH (htpl_pkg::ENTRY_W),
        .DEPTH (htpl_pkg::TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (AW'(i_slot_index)),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write) begin
            r_valid[AW'(i_slot_index)] <= 1'b1;
        end
    end

    assign w_mark    = w_rdata[htpl_pkg::ENTRY_W-1 -: htpl_pkg::MARK_W];
    assign w_st_hash = w_rdata[htpl_pkg::KEY_W +: htpl_pkg::HASH_W];
    assign w_st_key  = w_rdata[htpl_pkg::KEY_W-1:0];
    assign w_used    = r_vld && w_mark[0];
    assign w_deleted = w_mark[1];
    assign w_match   = w_used && !w_deleted && (w_st_hash == r_hash) &&
                       keys_equal(r_key_type, w_st_key, r_key);
    assign w_last    = (r_n == htpl_pkg::PROBE_W'(htpl_pkg::PROBE_LIMIT - 1));
    assign w_done    = !w_used || w_match || w_last;

    always_comb begin
        if (!w_used) begin
            n_out_slot    = r_have_free ? r_free : r_slot;
            n_out_outcome = r_have_free ? htpl_pkg::OUT_DELETED : htpl_pkg::OUT_EMPTY;
        end else if (w_match) begin
            n_out_slot    = r_slot;
            n_out_outcome = htpl_pkg::OUT_FOUND;
        end else begin
            n_out_slot    = '0;
            n_out_outcome = htpl_pkg::OUT_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_vld  <= r_valid[w_raddr];
            r_slot <= w_raddr;
        end
        if (i_cmd.start) begin
            r_hash      <= i_hash;
            r_key       <= i_key;
            r_perturb   <= i_hash;
            r_i         <= AW'(i_hash);
            r_n         <= '0;
            r_have_free <= 1'b0;
        end else if (i_cmd.step) begin
            r_perturb <= r_perturb >> htpl_pkg::PERTURB_STEP_BITS;
            r_i       <= n_i;
            r_n       <= r_n + htpl_pkg::PROBE_W'(1);
            if (w_deleted && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_slot    <= n_out_slot;
            r_out_outcome <= n_out_outcome;
        end
    end

    assign o_status.done     = w_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_slot            = 8'(r_out_slot);
    assign o_outcome         = r_out_outcome;

endmodule

@@ rtl/core/hash_table_perturbed_probe_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// Hash table perturbed probe lookup unit
// Open-addressing table with slot writes and perturbed-probe key lookups.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                  Word
// in       in   i_in_valid / o_in_ready    operation, slot_index, slot_used,
//                                          slot_deleted, hash, key
// out      out  o_out_valid / i_out_ready  slot, outcome
// cfg      in   i_cfg_we                   cfg_index, cfg_data
//
// A write word is stored while the unit is idle and leaves it ready. A lookup
// makes at most PROBE_LIMIT probes, each one read of the slot RAM.
// Reset clears the slot valid flags at once, so there is no clearing pass.
// A finished lookup holds in its last probe while the result register is full and i_out_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_table_perturbed_probe_lookup_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [htpl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [htpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic [7:0]                      i_slot_index,
    input  logic                            i_slot_used,
    input  logic                            i_slot_deleted,
    input  logic signed [63:0]              i_hash,
    input  logic [63:0]                     i_key,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_slot,
    output logic [1:0]                      o_outcome
);

    htpl_pkg::t_cmd    w_cmd;
    htpl_pkg::t_status w_status;

    htpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    htpl_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_slot_index   (i_slot_index),
        .i_slot_used    (i_slot_used),
        .i_slot_deleted (i_slot_deleted),
        .i_hash         (i_hash),
        .i_key          (i_key),
        .i_cmd          (w_cmd),
        .i_out_ready    (i_out_ready),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_slot         (o_slot),
        .o_outcome      (o_outcome)
    );

`include "hash_table_perturbed_probe_lookup_unit_assert.svh"

    `HTPL_ASSERT_NOW(a_finish_needs_room, w_cmd.finish, (!o_out_valid || i_out_ready),
        "lookup result loaded while the output register is occupied")
    `HTPL_ASSERT_NEXT(a_lookup_goes_busy, w_cmd.start, (!o_in_ready),
        "input still ready in the cycle after a lookup was accepted")
    `HTPL_ASSERT_NEXT(a_write_stays_ready, w_cmd.write, o_in_ready,
        "slot write left the unit busy")
    `HTPL_ASSERT_NOW(a_step_excludes_finish, w_cmd.step, (!w_cmd.finish && !o_in_ready),
        "probe step issued together with a finish or while accepting words")

endmodule
